@@ hdl/jpeg_exif_orientation_finder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the Exif orientation finder
// Implication checks, same-cycle and next-cycle, compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef JPEG_EXIF_ORIENTATION_FINDER_UNIT_DEFINES_SVH
`define JPEG_EXIF_ORIENTATION_FINDER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define JEOF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("jeof: same-cycle check failed");
`define JEOF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jeof: next-cycle check failed");
`else
`define JEOF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define JEOF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/jeof_pkg.sv @@
// ----------------------------------------------------------------------------
// jeof_pkg
// Constants, shared types and byte-order helpers of the orientation finder.
// ----------------------------------------------------------------------------
`default_nettype none

package jeof_pkg;

    localparam int SegmentBytes = 65536;
    localparam int HdrBytes     = 14;
    localparam int EntryBytes   = 12;
    localparam int ExifHdrBytes = 6;

    localparam logic [7:0]  MarkFill = 8'hFF;
    localparam logic [7:0]  MarkSoi  = 8'hD8;
    localparam logic [7:0]  MarkEoi  = 8'hD9;
    localparam logic [7:0]  MarkSos  = 8'hDA;
    localparam logic [7:0]  MarkTem  = 8'h01;
    localparam logic [7:0]  MarkRst0 = 8'hD0;
    localparam logic [7:0]  MarkApp1 = 8'hE1;

    localparam logic [47:0] ExifSig   = 48'h4578_6966_0000;
    localparam logic [15:0] OrderLe   = 16'h4949;
    localparam logic [15:0] OrderBe   = 16'h4D4D;
    localparam logic [15:0] TiffMagic = 16'd42;
    localparam logic [15:0] TagOrient = 16'h0112;
    localparam logic [15:0] TypeShort = 16'd3;

    typedef struct packed {
        logic        start;
        logic [15:0] seg_size;
        logic [31:0] tiff_start;
    } t_jeof_kick;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        hit;
        logic        stop;
        logic [3:0]  orientation;
        logic [31:0] tag_offset;
        logic        big_endian;
    } t_jeof_res;

    function automatic logic [15:0] jeof_get16(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic be);
        return be ? {b0, b1} : {b1, b0};
    endfunction

    function automatic logic [31:0] jeof_get32(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic be);
        return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
    endfunction

endpackage

`default_nettype wire

@@ hdl/jeof_seg_mem.sv @@
// ----------------------------------------------------------------------------
// jeof_seg_mem
// APP1 segment byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jeof_seg_mem #(
    parameter int  SEGMENT_BYTES = jeof_pkg::SegmentBytes,
    localparam int AW            = $clog2(SEGMENT_BYTES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [SEGMENT_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/jeof_ifd_walk.sv @@
// ----------------------------------------------------------------------------
// jeof_ifd_walk
// Reads a stored Exif segment: TIFF header check, then first-IFD tag search.
// ----------------------------------------------------------------------------
`default_nettype none

module jeof_ifd_walk #(
    parameter int  SEGMENT_BYTES = jeof_pkg::SegmentBytes,
    localparam int AW            = $clog2(SEGMENT_BYTES)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire jeof_pkg::t_jeof_kick i_kick,
    output logic                    o_rd_en,
    output logic [AW-1:0]           o_rd_addr,
    input  wire logic [7:0]         i_rd_data,
    output jeof_pkg::t_jeof_res     o_res
);
    import jeof_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_READ    = 7'b0000010,
        S_HDR     = 7'b0000100,
        S_CNT     = 7'b0001000,
        S_ENT_CHK = 7'b0010000,
        S_ENT     = 7'b0100000,
        S_VAL     = 7'b1000000
    } t_walk_state;

    t_walk_state r_state, r_ret;
    logic [15:0]   r_tsz;
    logic [31:0]   r_tstart;
    logic          r_be;
    logic [31:0]   r_ifd;
    logic [15:0]   r_count;
    logic [15:0]   r_idx;
    logic [33:0]   r_entry;
    logic [AW-1:0] r_rd_base;
    logic [3:0]    r_rd_n;
    logic [3:0]    r_rd_cnt;
    logic          r_pend;
    logic [3:0]    r_pend_idx;
    logic [7:0]    r_buf [HdrBytes];
    logic          r_done, r_hit, r_stop;
    logic [3:0]    r_orient;
    logic [31:0]   r_voff;

    logic [33:0] w_tsz;
    logic        w_hdr_be;
    logic        w_order_ok;
    logic [15:0] w_magic;
    logic [31:0] w_ifd;
    logic [15:0] w_h0, w_h1;
    logic [31:0] w_w1;

    assign w_tsz      = {18'd0, r_tsz};
    assign w_hdr_be   = ({r_buf[6], r_buf[7]} == OrderBe);
    assign w_order_ok = w_hdr_be || ({r_buf[6], r_buf[7]} == OrderLe);
    assign w_magic    = jeof_get16(r_buf[8], r_buf[9], w_hdr_be);
    assign w_ifd      = jeof_get32(r_buf[10], r_buf[11], r_buf[12], r_buf[13], w_hdr_be);
    assign w_h0       = jeof_get16(r_buf[0], r_buf[1], r_be);
    assign w_h1       = jeof_get16(r_buf[2], r_buf[3], r_be);
    assign w_w1       = jeof_get32(r_buf[4], r_buf[5], r_buf[6], r_buf[7], r_be);

    assign o_rd_en   = (r_state == S_READ) && (r_rd_cnt != r_rd_n);
    assign o_rd_addr = r_rd_base + AW'(r_rd_cnt);

    always_ff @(posedge i_clk) begin
        r_pend     <= o_rd_en;
        r_pend_idx <= r_rd_cnt;
        if (r_pend) begin
            r_buf[r_pend_idx] <= i_rd_data;
        end
        if (o_rd_en) begin
            r_rd_cnt <= r_rd_cnt + 4'd1;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_kick.start) begin
                        r_tsz     <= i_kick.seg_size - 16'(ExifHdrBytes);
                        r_tstart  <= i_kick.tiff_start;
                        r_hit     <= 1'b0;
                        r_stop    <= 1'b0;
                        r_rd_base <= '0;
                        r_rd_n    <= 4'(HdrBytes);
                        r_rd_cnt  <= '0;
                        r_ret     <= S_HDR;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_rd_cnt == r_rd_n && !r_pend) begin
                        r_state <= r_ret;
                    end
                end
                S_HDR: begin
                    r_be <= w_hdr_be;
                    if ({r_buf[0], r_buf[1], r_buf[2], r_buf[3], r_buf[4], r_buf[5]}
                            == ExifSig && w_order_ok && w_magic == TiffMagic
                            && ({2'd0, w_ifd} + 34'd2 <= w_tsz)) begin
                        r_ifd     <= w_ifd;
                        r_rd_base <= AW'(w_ifd + 32'(ExifHdrBytes));
                        r_rd_n    <= 4'd2;
                        r_rd_cnt  <= '0;
                        r_ret     <= S_CNT;
                        r_state   <= S_READ;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CNT: begin
                    r_count <= w_h0;
                    r_idx   <= '0;
                    r_entry <= {2'd0, r_ifd} + 34'd2;
                    r_state <= S_ENT_CHK;
                end
                S_ENT_CHK: begin
                    if (r_idx >= r_count || r_entry + 34'd8 > w_tsz) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_rd_base <= AW'(r_entry + 34'(ExifHdrBytes));
                        r_rd_n    <= 4'd8;
                        r_rd_cnt  <= '0;
                        r_ret     <= S_ENT;
                        r_state   <= S_READ;
                    end
                end
                S_ENT: begin
                    if (w_h0 == TagOrient && w_h1 == TypeShort && w_w1 == 32'd1
                            && r_entry + 34'd10 <= w_tsz) begin
                        r_rd_base <= AW'(r_entry + 34'(ExifHdrBytes + 8));
                        r_rd_n    <= 4'd2;
                        r_rd_cnt  <= '0;
                        r_ret     <= S_VAL;
                        r_state   <= S_READ;
                    end else begin
                        r_idx   <= r_idx + 16'd1;
                        r_entry <= r_entry + 34'(EntryBytes);
                        r_state <= S_ENT_CHK;
                    end
                end
                S_VAL: begin
                    r_stop   <= 1'b1;
                    r_hit    <= (w_h0 >= 16'd1) && (w_h0 <= 16'd8);
                    r_orient <= w_h0[3:0];
                    r_voff   <= r_tstart + r_entry[31:0] + 32'd8;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_res.busy         = (r_state != S_IDLE);
        o_res.done         = r_done;
        o_res.hit          = r_hit;
        o_res.stop         = r_stop;
        o_res.orientation  = r_orient;
        o_res.tag_offset   = r_voff;
        o_res.big_endian   = r_be;
    end

endmodule

`default_nettype wire

@@ hdl/jpeg_exif_orientation_finder_unit.sv @@
// ----------------------------------------------------------------------------
// jpeg_exif_orientation_finder_unit
// Walks JPEG markers byte by byte, stores APP1 segments, finds Exif orientation.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload
//  in      | i_valid | o_ready | i_data_byte, i_last_byte
//  out     | o_valid | i_ready | o_found, o_orientation, o_tag_offset, o_big_endian
//
//  One byte per cycle while the marker walk runs.
//  At the end of an APP1 segment of at least 14 bytes input stalls for the IFD
//  walk, which reads the header and entry count, then each IFD entry examined,
//  then the value on a tag match, all through the single memory read port.
//  Segment writes and walker reads never overlap.
//  Reset: synchronous, active low; no clearing pass over the segment store.
//  A pending result blocks input only if it is still untaken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jpeg_exif_orientation_finder_unit_defines.svh"

module jpeg_exif_orientation_finder_unit #(
    parameter int  SEGMENT_BYTES = jeof_pkg::SegmentBytes,
    localparam int AW            = $clog2(SEGMENT_BYTES)
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic [3:0]       o_orientation,
    output logic [31:0]      o_tag_offset,
    output logic             o_big_endian
);
    import jeof_pkg::*;

    typedef enum logic [7:0] {
        P_SOI0 = 8'b00000001,
        P_SOI1 = 8'b00000010,
        P_MARK = 8'b00000100,
        P_FILL = 8'b00001000,
        P_LENH = 8'b00010000,
        P_LENL = 8'b00100000,
        P_BODY = 8'b01000000,
        P_DONE = 8'b10000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos;
    logic [7:0]  r_marker;
    logic [7:0]  r_len_hi;
    logic [15:0] r_remaining;
    logic [15:0] r_fill;
    logic [31:0] r_tiff_start;
    logic        r_walking;
    logic        r_last_pend;
    logic        r_held_found;
    logic [3:0]  r_held_orient;
    logic [31:0] r_held_voff;
    logic        r_held_be;
    logic        r_o_valid;
    logic        r_o_found;
    logic [3:0]  r_o_orient;
    logic [31:0] r_o_voff;
    logic        r_o_be;

    logic        w_accept;
    logic        w_store;
    logic [15:0] w_len;
    logic        w_seg_end;
    t_jeof_kick  w_kick;
    t_jeof_res   w_res;
    logic        w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]  w_rd_data;
    logic        w_emit;
    logic        w_fin_found;
    logic [3:0]  w_fin_orient;
    logic [31:0] w_fin_voff;
    logic        w_fin_be;

    assign o_ready  = !r_walking && (!r_o_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_len    = {r_len_hi, i_data_byte};
    assign w_store  = w_accept && (r_phase == P_BODY) && (r_marker == MarkApp1);
    assign w_seg_end = (r_phase == P_BODY) && (r_remaining == 16'd1);

    assign w_kick.start      = w_accept && w_seg_end && (r_marker == MarkApp1)
                               && (r_fill + 16'd1 >= 16'(HdrBytes));
    assign w_kick.seg_size   = r_fill + 16'd1;
    assign w_kick.tiff_start = r_tiff_start;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            P_SOI0: n_phase = (i_data_byte == MarkFill) ? P_SOI1 : P_DONE;
            P_SOI1: n_phase = (i_data_byte == MarkSoi) ? P_MARK : P_DONE;
            P_MARK: n_phase = (i_data_byte == MarkFill) ? P_FILL : P_DONE;
            P_FILL: begin
                if (i_data_byte == MarkFill) begin
                    n_phase = P_FILL;
                end else if (i_data_byte == MarkEoi || i_data_byte == MarkSos) begin
                    n_phase = P_DONE;
                end else if (i_data_byte == MarkTem
                        || (i_data_byte >= MarkRst0 && i_data_byte <= MarkSoi)) begin
                    n_phase = P_MARK;
                end else begin
                    n_phase = P_LENH;
                end
            end
            P_LENH: n_phase = P_LENL;
            P_LENL: begin
                if (w_len < 16'd2) begin
                    n_phase = P_DONE;
                end else if (w_len == 16'd2) begin
                    n_phase = P_MARK;
                end else begin
                    n_phase = P_BODY;
                end
            end
            P_BODY: n_phase = w_seg_end ? P_MARK : P_BODY;
            P_DONE: n_phase = P_DONE;
            default: n_phase = P_DONE;
        endcase
    end

    // file result: walker hit takes precedence over held values
    assign w_emit       = (w_accept && i_last_byte && !w_kick.start)
                          || (w_res.done && r_last_pend);
    assign w_fin_found  = (w_res.done && w_res.hit) ? 1'b1 : r_held_found;
    assign w_fin_orient = (w_res.done && w_res.hit) ? w_res.orientation : r_held_orient;
    assign w_fin_voff   = (w_res.done && w_res.hit) ? w_res.tag_offset : r_held_voff;
    assign w_fin_be     = (w_res.done && w_res.hit) ? w_res.big_endian : r_held_be;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos <= r_pos + 32'd1;
            unique case (r_phase)
                P_FILL: begin
                    if (i_data_byte != MarkFill) begin
                        r_marker <= i_data_byte;
                    end
                end
                P_LENH: r_len_hi <= i_data_byte;
                P_LENL: begin
                    r_remaining  <= w_len - 16'd2;
                    r_fill       <= '0;
                    r_tiff_start <= r_pos + 32'd7;
                end
                P_BODY: begin
                    r_remaining <= r_remaining - 16'd1;
                    r_fill      <= r_fill + 16'd1;
                end
                default: ;
            endcase
        end
        if (w_emit) begin
            r_o_found  <= w_fin_found;
            r_o_orient <= w_fin_orient;
            r_o_voff   <= w_fin_voff;
            r_o_be     <= w_fin_be;
        end
        if (w_res.done && w_res.hit) begin
            r_held_orient <= w_res.orientation;
            r_held_voff   <= w_res.tag_offset;
            r_held_be     <= w_res.big_endian;
        end
        if (!i_rst_n || w_emit) begin
            r_pos         <= '0;
            r_held_orient <= 4'd1;
            r_held_voff   <= '0;
            r_held_be     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= P_SOI0;
            r_walking    <= 1'b0;
            r_last_pend  <= 1'b0;
            r_held_found <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            if (w_accept) begin
                r_phase <= n_phase;
            end
            if (w_kick.start) begin
                r_walking   <= 1'b1;
                r_last_pend <= i_last_byte;
            end
            if (w_res.done) begin
                r_walking <= 1'b0;
                if (w_res.stop) begin
                    r_phase <= P_DONE;
                end
                if (w_res.hit) begin
                    r_held_found <= 1'b1;
                end
            end
            if (w_emit) begin
                r_o_valid    <= 1'b1;
                r_phase      <= P_SOI0;
                r_last_pend  <= 1'b0;
                r_held_found <= 1'b0;
            end
        end
    end

    jeof_seg_mem #(
        .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_seg_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_store),
        .i_wr_addr (AW'(r_fill)),
        .i_wr_data (i_data_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    jeof_ifd_walk #(
        .SEGMENT_BYTES(SEGMENT_BYTES)
    ) u_ifd_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kick    (w_kick),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_res     (w_res)
    );

    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_orientation  = r_o_orient;
    assign o_tag_offset   = r_o_voff;
    assign o_big_endian   = r_o_be;

    `JEOF_ASSERT_IMP(a_found_range, i_clk, i_rst_n, o_valid && o_found, (o_orientation >= 4'd1) && (o_orientation <= 4'd8))
    `JEOF_ASSERT_IMP(a_miss_defaults, i_clk, i_rst_n, o_valid && !o_found, (o_orientation == 4'd1) && (o_tag_offset == 32'd0) && !o_big_endian)
    `JEOF_ASSERT_NXT(a_kick_stalls, i_clk, i_rst_n, w_kick.start, !o_ready && w_res.busy)
    `JEOF_ASSERT_IMP(a_no_store_walk, i_clk, i_rst_n, w_res.busy, !w_store)

endmodule

`default_nettype wire

@@ tb/sv/tb_jpeg_exif_orientation_finder_unit.sv @@
// ----------------------------------------------------------------------------
// Exif orientation finder testbench
// Streams whole JPEG files byte by byte into the finder: short directed files
// first, then random ones built from marker walks, Exif APP1 segments with
// random IFDs, broken headers and plain noise. A byte-level predictor computes
// the expected result of each file; both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_jpeg_exif_orientation_finder_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import jeof_pkg::*;

    localparam int         RunLimit = 2000000;
    localparam logic [7:0] MarkApp0 = 8'hE0;
    localparam logic [7:0] MarkDqt  = 8'hDB;
    localparam logic [7:0] MarkDht  = 8'hC4;
    localparam logic [7:0] MarkSof0 = 8'hC0;
    localparam logic [7:0] MarkCom  = 8'hFE;
    localparam logic [7:0] MarkApp2 = 8'hE2;

    typedef enum logic [2:0] {
        WALK_SOI0, WALK_SOI1, WALK_MARK, WALK_FILL,
        WALK_LENH, WALK_LENL, WALK_BODY, WALK_DONE
    } t_walk;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_file_byte;

    typedef struct {
        logic        found;
        logic [3:0]  orientation;
        logic [31:0] tag_offset;
        logic        big_endian;
    } t_orient_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_found, o_big_endian;
    logic [3:0]  o_orientation;
    logic [31:0] o_tag_offset;

    jpeg_exif_orientation_finder_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_found(o_found), .o_orientation(o_orientation),
        .o_tag_offset(o_tag_offset), .o_big_endian(o_big_endian)
    );

    always #10 i_clk = ~i_clk;

    t_file_byte     pending_bytes[$];
    t_orient_result expected_results[$];
    int             mismatches = 0;
    int             cycle_count = 0;
    bit             calm = 0;

    // finder state mirror
    t_walk       walk;
    logic [31:0] file_pos;
    logic [7:0]  marker;
    logic [7:0]  len_hi;
    logic [15:0] seg_left;
    logic [7:0]  app1_store[SegmentBytes];
    int unsigned seg_fill;
    logic [31:0] tiff_start;
    logic        tiff_be;
    logic        hit_found;
    logic [3:0]  hit_orient;
    logic [31:0] hit_offset;
    logic        hit_be;

    function automatic void clear_finder();
        walk = WALK_SOI0;
        file_pos = '0;
        marker = '0;
        len_hi = '0;
        seg_left = '0;
        seg_fill = 0;
        tiff_start = '0;
        tiff_be = 1'b0;
        hit_found = 1'b0;
        hit_orient = 4'd1;
        hit_offset = '0;
        hit_be = 1'b0;
    endfunction

    function automatic logic [7:0] tiff_at(longint off);
        return (off + 6 < SegmentBytes) ? app1_store[off + 6] : 8'h00;
    endfunction

    function automatic bit tiff_rd16(longint tsz, longint off, output logic [31:0] v);
        logic [7:0] a, b;
        if (off > tsz || tsz - off < 2) return 0;
        a = tiff_at(off);
        b = tiff_at(off + 1);
        v = tiff_be ? {16'h0, a, b} : {16'h0, b, a};
        return 1;
    endfunction

    function automatic bit tiff_rd32(longint tsz, longint off, output logic [31:0] v);
        logic [31:0] h, l;
        if (off > tsz || tsz - off < 4) return 0;
        void'(tiff_rd16(tsz, off, h));
        void'(tiff_rd16(tsz, off + 2, l));
        v = tiff_be ? {h[15:0], l[15:0]} : {l[15:0], h[15:0]};
        return 1;
    endfunction

    function automatic void search_ifd();
        longint      tsz, entry;
        logic [31:0] magic, ifd, cnt, tag, typ, comps, val;
        if (marker != MarkApp1 || seg_fill < HdrBytes || seg_fill > SegmentBytes) return;
        for (int k = 0; k < ExifHdrBytes; k++)
            if (app1_store[k] != ExifSig[47 - 8 * k -: 8]) return;
        tsz = longint'(seg_fill) - ExifHdrBytes;
        if ({app1_store[6], app1_store[7]} == OrderLe) tiff_be = 1'b0;
        else if ({app1_store[6], app1_store[7]} == OrderBe) tiff_be = 1'b1;
        else return;
        if (!tiff_rd16(tsz, 2, magic) || magic[15:0] != TiffMagic) return;
        if (!tiff_rd32(tsz, 4, ifd)) return;
        if (!tiff_rd16(tsz, longint'(ifd), cnt)) return;
        for (longint i = 0; i < cnt; i++) begin
            entry = longint'(ifd) + 2 + i * EntryBytes;
            if (!tiff_rd16(tsz, entry, tag) || !tiff_rd16(tsz, entry + 2, typ) ||
                !tiff_rd32(tsz, entry + 4, comps))
                break;
            if (tag[15:0] != TagOrient || typ[15:0] != TypeShort || comps != 1) continue;
            if (!tiff_rd16(tsz, entry + 8, val)) continue;
            if (val >= 1 && val <= 8) begin
                hit_found = 1'b1;
                hit_orient = val[3:0];
                hit_offset = tiff_start + 32'(entry + 8);
                hit_be = tiff_be;
            end
            walk = WALK_DONE;
            return;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [15:0]    seg_len;
        t_orient_result r;
        case (walk)
            WALK_SOI0: walk = (b == MarkFill) ? WALK_SOI1 : WALK_DONE;
            WALK_SOI1: walk = (b == MarkSoi) ? WALK_MARK : WALK_DONE;
            WALK_MARK: walk = (b == MarkFill) ? WALK_FILL : WALK_DONE;
            WALK_FILL: begin
                if (b != MarkFill) begin
                    marker = b;
                    if (b == MarkEoi || b == MarkSos) walk = WALK_DONE;
                    else if (b == MarkTem || (b >= MarkRst0 && b <= MarkSoi)) walk = WALK_MARK;
                    else walk = WALK_LENH;
                end
            end
            WALK_LENH: begin
                len_hi = b;
                walk = WALK_LENL;
            end
            WALK_LENL: begin
                seg_len = {len_hi, b};
                if (seg_len < 2) begin
                    walk = WALK_DONE;
                end else begin
                    seg_left = seg_len - 2;
                    seg_fill = 0;
                    tiff_start = file_pos + 7;
                    if (seg_left == 0) begin
                        walk = WALK_MARK;
                        search_ifd();
                    end else begin
                        walk = WALK_BODY;
                    end
                end
            end
            WALK_BODY: begin
                if (marker == MarkApp1 && seg_fill < SegmentBytes) app1_store[seg_fill] = b;
                seg_fill++;
                seg_left--;
                if (seg_left == 0) begin
                    walk = WALK_MARK;
                    search_ifd();
                end
            end
            default: walk = WALK_DONE;
        endcase
        file_pos++;
        if (last) begin
            r.found = hit_found;
            r.orientation = hit_found ? hit_orient : 4'd1;
            r.tag_offset = hit_found ? hit_offset : 32'd0;
            r.big_endian = hit_found ? hit_be : 1'b0;
            expected_results.push_back(r);
            clear_finder();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---- stimulus builders ----
    function automatic void put16(ref logic [7:0] q[$], input logic [15:0] v, input bit be);
        if (be) begin q.push_back(v[15:8]); q.push_back(v[7:0]); end
        else begin q.push_back(v[7:0]); q.push_back(v[15:8]); end
    endfunction

    function automatic void put32(ref logic [7:0] q[$], input logic [31:0] v, input bit be);
        put16(q, be ? v[31:16] : v[15:0], be);
        put16(q, be ? v[15:0] : v[31:16], be);
    endfunction

    // fault: 0 none, 1 header, 2 byte order, 3 magic, 4 IFD offset, 5 no tag,
    // 6 wrong type, 7 wrong count, 8 truncated
    function automatic void exif_payload(ref logic [7:0] s[$], input bit be,
                                         input logic [15:0] orient, input int fault);
        int n, k, cut;
        s = {};
        for (int j = 0; j < ExifHdrBytes; j++) s.push_back(ExifSig[47 - 8 * j -: 8]);
        if (fault == 1) s[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));
        if (fault == 2) begin s.push_back(OrderLe[15:8]); s.push_back(OrderBe[7:0]); end
        else if (be) begin s.push_back(OrderBe[15:8]); s.push_back(OrderBe[7:0]); end
        else begin s.push_back(OrderLe[15:8]); s.push_back(OrderLe[7:0]); end
        put16(s, (fault == 3) ? TiffMagic + 16'($urandom_range(1, 9)) : TiffMagic, be);
        put32(s, (fault == 4) ? $urandom_range(0, 300) : 32'd8, be);
        n = $urandom_range(1, 5);
        k = (fault == 5) ? -1 : $urandom_range(0, n - 1);
        put16(s, 16'(n), be);
        for (int i = 0; i < n; i++) begin
            put16(s, (i == k) ? TagOrient : 16'($urandom), be);
            put16(s, (i == k) ? ((fault == 6) ? 16'd4 : TypeShort) : 16'($urandom_range(1, 12)), be);
            put32(s, (i == k && fault == 7) ? 32'd2 : ((i == k) ? 32'd1 : $urandom_range(0, 3)), be);
            put16(s, (i == k) ? orient : 16'($urandom), be);
            put16(s, 16'($urandom), be);
        end
        put32(s, 32'd0, be);
        repeat ($urandom_range(0, 4)) s.push_back(8'($urandom));
        if (fault == 8) begin
            cut = $urandom_range(0, s.size() - 1);
            while (s.size() > cut) void'(s.pop_back());
        end
    endfunction

    function automatic void put_segment(ref logic [7:0] f[$], input logic [7:0] code,
                                        ref logic [7:0] body[$]);
        logic [15:0] len;
        len = 16'(body.size() + 2);
        f.push_back(MarkFill);
        f.push_back(code);
        f.push_back(len[15:8]);
        f.push_back(len[7:0]);
        foreach (body[j]) f.push_back(body[j]);
    endfunction

    function automatic logic [15:0] pick_orient();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'd9;
        if (r == 2) return 16'($urandom);
        return 16'($urandom_range(1, 8));
    endfunction

    function automatic void queue_file(ref logic [7:0] f[$]);
        t_file_byte fb;
        foreach (f[j]) begin
            fb.data = f[j];
            fb.last = (j == f.size() - 1);
            pending_bytes.push_back(fb);
        end
    endfunction

    function automatic void random_file();
        logic [7:0] f[$], body[$];
        logic [7:0] codes[6];
        int         mode, c;
        codes = '{MarkApp0, MarkDqt, MarkDht, MarkSof0, MarkCom, MarkApp2};
        mode = $urandom_range(0, 19);
        if (mode == 0) begin
            repeat ($urandom_range(1, 30)) f.push_back(8'($urandom));
            queue_file(f);
            return;
        end
        if (mode == 1) f.push_back(8'($urandom)); else f.push_back(MarkFill);
        if (mode == 2) f.push_back(8'($urandom)); else f.push_back(MarkSoi);
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0) f.push_back(MarkFill);
            c = $urandom_range(0, 19);
            if (c < 3) begin
                f.push_back(MarkFill);
                f.push_back($urandom_range(0, 1) ? MarkTem : 8'(MarkRst0 + $urandom_range(0, 8)));
            end else if (c < 7) begin
                body = {};
                repeat ($urandom_range(0, 16)) body.push_back(8'($urandom));
                put_segment(f, codes[$urandom_range(0, 5)], body);
            end else if (c == 7) begin
                f.push_back(8'($urandom_range(0, 254)));
            end else if (c == 8) begin
                f.push_back(MarkFill);
                f.push_back(MarkApp0);
                f.push_back(8'h00);
                f.push_back(8'($urandom_range(0, 1)));
            end else begin
                exif_payload(body, $urandom_range(0, 1), pick_orient(),
                             ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0);
                put_segment(f, MarkApp1, body);
            end
        end
        c = $urandom_range(0, 5);
        if (c < 2) begin
            f.push_back(MarkFill);
            f.push_back(MarkEoi);
        end else if (c < 4) begin
            f.push_back(MarkFill);
            f.push_back(MarkSos);
            repeat ($urandom_range(0, 12)) f.push_back(8'($urandom));
        end else if (c == 4 && f.size() > 1) begin
            c = $urandom_range(1, f.size() - 1);
            while (f.size() > c) void'(f.pop_back());
        end
        repeat ($urandom_range(0, 3)) f.push_back(8'($urandom));
        queue_file(f);
    endfunction

    // ---- driver ----
    int in_gap = 0;
    t_file_byte nxt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) predict_byte(i_data_byte, i_last_byte);
            if (!i_valid || o_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    nxt = pending_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_last_byte <= nxt.last;
                    in_gap <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor ----
    int out_gap = 0;
    t_orient_result want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: found=%0b orient=%0d",
                                 o_found, o_orientation);
                end else begin
                    want = expected_results.pop_front();
                    if (o_found !== want.found || o_orientation !== want.orientation ||
                        o_tag_offset !== want.tag_offset ||
                        o_big_endian !== want.big_endian) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0b/%0d/%h/%0b got %0b/%0d/%h/%0b",
                                     want.found, want.orientation, want.tag_offset,
                                     want.big_endian, o_found, o_orientation,
                                     o_tag_offset, o_big_endian);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                out_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RunLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [7:0] f[$], body[$];
        clear_finder();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed files
        f = '{MarkFill};
        queue_file(f);
        f = '{8'h00, MarkSoi, MarkFill, MarkEoi};
        queue_file(f);
        f = '{MarkFill, MarkSoi, 8'h7F, MarkEoi};
        queue_file(f);
        f = '{MarkFill, MarkSoi, MarkFill, MarkFill, MarkTem, MarkFill, MarkApp0, 8'h00, 8'h01};
        queue_file(f);
        f = '{MarkFill, MarkSoi};
        exif_payload(body, 0, 16'd8, 0);
        put_segment(f, MarkApp1, body);
        f.push_back(MarkFill);
        f.push_back(MarkSos);
        queue_file(f);
        f = '{MarkFill, MarkSoi};
        exif_payload(body, 1, 16'd1, 0);
        put_segment(f, MarkApp1, body);
        queue_file(f);
        f = '{MarkFill, MarkSoi};
        exif_payload(body, 1, 16'd9, 0);
        put_segment(f, MarkApp1, body);
        f.push_back(8'h00);
        queue_file(f);
        f = '{MarkFill, MarkSoi};
        exif_payload(body, 0, 16'd0, 0);
        put_segment(f, MarkApp1, body);
        void'(f.pop_back());
        queue_file(f);

        while (pending_bytes.size() < 1300) begin
            calm = ($urandom_range(0, 7) == 0);
            random_file();
        end
        while (pending_bytes.size() > 0 || i_valid) @(posedge i_clk);
        calm = 0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
